// File: design/spxc_pkg.sv
// Shared constants, result type and character helpers for the sentence parser.
package spxc_pkg;

	// Framing characters
	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	// Field number saturates here; fields at or above it are dropped
	localparam logic [4:0] FIELD_SAT = 5'd19;

	// Per-field capture limits
	localparam logic [4:0] NAME_FIELD_CHARS  = 5'd12;
	localparam logic [4:0] VALUE_FIELD_CHARS = 5'd9;
	localparam logic [4:0] FIELD0_CHARS      = 5'd5;
	localparam logic [4:0] FIELD1_CHARS      = 5'd10;
	localparam logic [4:0] FIELD2_CHARS      = 5'd16;

	// Widths of the stream payloads
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;

	// One result item
	typedef struct packed {
		logic       sentence_good;
		logic       sentence_done;
		logic [7:0] char_value;
		logic [3:0] char_index;
		logic [4:0] field_number;
		logic       char_store;
		logic       sentence_start;
	} res_t;

	// Number of characters a field may capture
	function automatic logic [4:0] field_limit(input logic [4:0] f);
		logic [4:0] lim;
		if (f == 5'd0) begin
			lim = FIELD0_CHARS;
		end else if (f == 5'd1) begin
			lim = FIELD1_CHARS;
		end else if (f == 5'd2) begin
			lim = FIELD2_CHARS;
		end else if (f >= FIELD_SAT) begin
			lim = 5'd0;
		end else if (f[0]) begin
			lim = NAME_FIELD_CHARS;
		end else begin
			lim = VALUE_FIELD_CHARS;
		end
		return lim;
	endfunction

	// Uppercase ASCII hex digit of a nibble
	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] d;
		if (v < 4'd10) begin
			d = 8'h30 + {4'd0, v};
		end else begin
			d = 8'h37 + {4'd0, v};
		end
		return d;
	endfunction

	// Upper-case 'a'..'z' only
	function automatic logic [7:0] upcase(input logic [7:0] c);
		logic [7:0] u;
		if (c >= 8'h61 && c <= 8'h7A) begin
			u = c - 8'h20;
		end else begin
			u = c;
		end
		return u;
	endfunction

endpackage

// File: design/sentence_parser_xor_checksum.sv
// Top level: comma-separated sentence parser with XOR checksum verdict.
//
// Usage: one received character enters per item on the s_ channel; exactly one
// result item leaves on the m_ channel for every character, in order. A result
// flags a sentence start ('$'), a captured field character with its field
// number and position, or the checksum verdict given on the byte that follows
// the two checksum characters; results for all other bytes flag nothing.
// Path: an accepted item passes the input register, then the result register,
// before its result is offered on the m_ channel. Throughput: one item per
// cycle while m_tready stays high; the parser state advances as an item moves
// from the input register into the result register, so back-to-back items
// need no gap.
// Stall: when m_tready is low, the result register holds and the input
// register holds one further item; s_tready drops only when both are full.
// Reset: arst_n clears the parser state and both valid flags; the first
// sentence starts with the first '$' after reset.
module sentence_parser_xor_checksum (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [spxc_pkg::IN_TDATA_W-1:0]  s_tdata,  // [7:0] rx_byte
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] sentence_start, [1] char_store, [6:2] field_number, [10:7] char_index,
	// [18:11] char_value, [19] sentence_done, [20] sentence_good, [23:21] zero
	output logic [spxc_pkg::OUT_TDATA_W-1:0] m_tdata
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           valid_s2;
	spxc_pkg::res_t res_s2;
	spxc_pkg::res_t res_comb;
	logic           adv_s2;
	logic           move_s1;

	assign adv_s2   = !valid_s2 || m_tready;
	assign move_s1  = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[7:0];
		end
	end

	// Parser state and decision
	spxc_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (move_s1),
		.rx_byte (byte_s1),
		.res     (res_comb)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'd0, res_s2};

	// Checks
	a_good_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.sentence_good |-> res_s2.sentence_done)
		else $error("verdict good without done");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $onehot0({res_s2.sentence_start, res_s2.char_store,
			res_s2.sentence_done}))
		else $error("result carries more than one kind");

	a_field_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.char_store |->
			(res_s2.field_number < spxc_pkg::FIELD_SAT) &&
			({1'b0, res_s2.char_index} < spxc_pkg::field_limit(res_s2.field_number)))
		else $error("captured character outside its field");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost an item under stall");

endmodule

// File: design/spxc_parser.sv
// Sentence parser state and the per-byte decision logic.
module spxc_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,       // byte handed on this cycle
	input  logic [7:0]          rx_byte,
	output spxc_pkg::res_t      res       // result for rx_byte against current state
);

	logic       in_sentence_q, in_sentence_d;
	logic       in_checksum_q, in_checksum_d;
	logic [1:0] cks_cnt_q, cks_cnt_d;
	logic [4:0] field_q, field_d;
	logic [4:0] pos_q, pos_d;
	logic [7:0] xor_q, xor_d;
	logic [7:0] high_q, high_d;
	logic [7:0] low_q, low_d;

	// Next state and result for one byte
	always_comb begin
		in_sentence_d = in_sentence_q;
		in_checksum_d = in_checksum_q;
		cks_cnt_d     = cks_cnt_q;
		field_d       = field_q;
		pos_d         = pos_q;
		xor_d         = xor_q;
		high_d        = high_q;
		low_d         = low_q;
		res           = '0;

		if (rx_byte == spxc_pkg::CH_START) begin
			// restart: clear everything
			in_sentence_d      = 1'b1;
			in_checksum_d      = 1'b0;
			cks_cnt_d          = 2'd0;
			field_d            = 5'd0;
			pos_d              = 5'd0;
			xor_d              = 8'd0;
			high_d             = 8'd0;
			low_d              = 8'd0;
			res.sentence_start = 1'b1;
		end else if (!in_sentence_q) begin
			// idle, byte ignored
		end else if (in_checksum_q) begin
			if (cks_cnt_q == 2'd0) begin
				high_d    = spxc_pkg::upcase(rx_byte);
				cks_cnt_d = 2'd1;
			end else if (cks_cnt_q == 2'd1) begin
				low_d     = spxc_pkg::upcase(rx_byte);
				cks_cnt_d = 2'd2;
			end else begin
				// verdict byte
				res.sentence_done = 1'b1;
				res.sentence_good = (high_q == spxc_pkg::hex_digit(xor_q[7:4])) &&
					(low_q == spxc_pkg::hex_digit(xor_q[3:0]));
				cks_cnt_d     = 2'd0;
				in_checksum_d = 1'b0;
				in_sentence_d = 1'b0;
			end
		end else if (rx_byte == spxc_pkg::CH_STAR) begin
			in_checksum_d = 1'b1;
			cks_cnt_d     = 2'd0;
		end else begin
			// body byte
			if (rx_byte == spxc_pkg::CH_COMMA) begin
				if (field_q < spxc_pkg::FIELD_SAT) begin
					field_d = field_q + 5'd1;
				end
				pos_d = 5'd0;
			end else if (pos_q < spxc_pkg::field_limit(field_q)) begin
				res.char_store   = 1'b1;
				res.field_number = field_q;
				res.char_index   = pos_q[3:0];
				res.char_value   = rx_byte;
				pos_d            = pos_q + 5'd1;
			end
			xor_d = xor_q ^ rx_byte;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sentence_q <= 1'b0;
			in_checksum_q <= 1'b0;
			cks_cnt_q     <= 2'd0;
			field_q       <= 5'd0;
			pos_q         <= 5'd0;
			xor_q         <= 8'd0;
			high_q        <= 8'd0;
			low_q         <= 8'd0;
		end else if (en) begin
			in_sentence_q <= in_sentence_d;
			in_checksum_q <= in_checksum_d;
			cks_cnt_q     <= cks_cnt_d;
			field_q       <= field_d;
			pos_q         <= pos_d;
			xor_q         <= xor_d;
			high_q        <= high_d;
			low_q         <= low_d;
		end
	end

endmodule

// File: sim/tb_sentence_parser_xor_checksum.sv
// Self-checking testbench for the sentence parser with XOR checksum verdict.
module tb_sentence_parser_xor_checksum;
	import spxc_pkg::*;

	localparam int ITEM_TARGET = 720;
	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD   = 120;
	localparam int DRAIN_WAIT  = 10;

	// Expected-result store and parser predictor
	class sentence_scoreboard;
		logic       active;
		logic       reading_sum;
		logic [1:0] sum_chars;
		logic [4:0] fld;
		logic [4:0] pos;
		logic [7:0] xor_acc;
		logic [7:0] sum_hi;
		logic [7:0] sum_lo;
		res_t       pending_q[$];
		int         n_errors;
		int         n_checked;
		int         n_starts;
		int         n_stored;
		int         n_good;
		int         n_bad;
		int         deepest_field;

		function new();
			clear_state();
			active = 1'b0;
			n_errors = 0;
			n_checked = 0;
			n_starts = 0;
			n_stored = 0;
			n_good = 0;
			n_bad = 0;
			deepest_field = 0;
		endfunction

		function void clear_state();
			reading_sum = 1'b0;
			sum_chars = 2'd0;
			fld = 5'd0;
			pos = 5'd0;
			xor_acc = 8'h00;
			sum_hi = 8'h00;
			sum_lo = 8'h00;
		endfunction

		// capture room of each field; saturated field keeps none
		static function logic [4:0] char_limit(input logic [4:0] f);
			logic [4:0] n;
			case (f)
				5'd0: n = 5'd5;
				5'd1: n = 5'd10;
				5'd2: n = 5'd16;
				default: begin
					if (f >= FIELD_SAT) n = 5'd0;
					else n = f[0] ? NAME_FIELD_CHARS : VALUE_FIELD_CHARS;
				end
			endcase
			return n;
		endfunction

		static function logic [7:0] hex_char(input logic [3:0] nib);
			string digits;
			digits = "0123456789ABCDEF";
			return digits[nib];
		endfunction

		static function logic [7:0] to_upper(input logic [7:0] c);
			logic [7:0] u;
			u = c;
			if (c >= 8'h61 && c <= 8'h7A) u = c & 8'hDF;
			return u;
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		// advance the parser on one accepted byte and queue its result
		function void note_byte(input logic [7:0] b);
			res_t r;
			r = '0;
			if (b == CH_START) begin
				clear_state();
				active = 1'b1;
				r.sentence_start = 1'b1;
				n_starts++;
			end else if (!active) begin
				// ignored outside a sentence
			end else if (reading_sum) begin
				case (sum_chars)
					2'd0: begin
						sum_hi = to_upper(b);
						sum_chars = 2'd1;
					end
					2'd1: begin
						sum_lo = to_upper(b);
						sum_chars = 2'd2;
					end
					default: begin
						r.sentence_done = 1'b1;
						r.sentence_good = (sum_hi == hex_char(xor_acc[7:4]))
							&& (sum_lo == hex_char(xor_acc[3:0]));
						if (r.sentence_good) n_good++;
						else n_bad++;
						sum_chars = 2'd0;
						reading_sum = 1'b0;
						active = 1'b0;
					end
				endcase
			end else if (b == CH_STAR) begin
				reading_sum = 1'b1;
				sum_chars = 2'd0;
			end else begin
				if (b == CH_COMMA) begin
					if (fld < FIELD_SAT) fld = fld + 5'd1;
					pos = 5'd0;
				end else if (pos < char_limit(fld)) begin
					r.char_store = 1'b1;
					r.field_number = fld;
					r.char_index = pos[3:0];
					r.char_value = b;
					pos = pos + 5'd1;
					n_stored++;
					if (int'(fld) > deepest_field) deepest_field = int'(fld);
				end
				xor_acc ^= b;
			end
			pending_q.push_back(r);
		endfunction

		function void mismatch(input string what, input int unsigned want,
				input int unsigned got);
			n_errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		endfunction

		// compare one result item with the oldest expectation
		function void check_result(input logic [OUT_TDATA_W-1:0] word);
			res_t want;
			res_t got;
			if (pending_q.size() == 0) begin
				n_errors++;
				$display("%0t: result %h with nothing expected", $time, word);
				return;
			end
			want = pending_q.pop_front();
			got = res_t'(word[$bits(res_t)-1:0]);
			n_checked++;
			if (got.sentence_start != want.sentence_start)
				mismatch("sentence_start", 32'(want.sentence_start),
					32'(got.sentence_start));
			if (got.char_store != want.char_store)
				mismatch("char_store", 32'(want.char_store), 32'(got.char_store));
			if (got.field_number != want.field_number)
				mismatch("field_number", 32'(want.field_number), 32'(got.field_number));
			if (got.char_index != want.char_index)
				mismatch("char_index", 32'(want.char_index), 32'(got.char_index));
			if (got.char_value != want.char_value)
				mismatch("char_value", 32'(want.char_value), 32'(got.char_value));
			if (got.sentence_done != want.sentence_done)
				mismatch("sentence_done", 32'(want.sentence_done),
					32'(got.sentence_done));
			if (got.sentence_good != want.sentence_good)
				mismatch("sentence_good", 32'(want.sentence_good),
					32'(got.sentence_good));
			if (word[OUT_TDATA_W-1:$bits(res_t)] != '0)
				mismatch("padding", 0, 32'(word[OUT_TDATA_W-1:$bits(res_t)]));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;  // [7:0] rx_byte
	logic m_tvalid;
	logic m_tready = 1'b0;
	// [0] sentence_start, [1] char_store, [6:2] field_number, [10:7] char_index,
	// [18:11] char_value, [19] sentence_done, [20] sentence_good, [23:21] zero
	logic [OUT_TDATA_W-1:0] m_tdata;

	sentence_scoreboard sb = new();
	int  n_sent = 0;
	int  cycles = 0;
	bit  burst = 1'b0;
	bit  held = 1'b0;

	sentence_parser_xor_checksum dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: no progress, cycle limit reached", $time);
			$display("[sentence_parser_xor_checksum] ERROR");
			$finish;
		end
	end

	// monitors on both channels
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) sb.note_byte(s_tdata);
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	// receiver: random stalls, free-running stretches and one long hold-off
	initial begin : result_sink
		int run;
		int gap;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!held && sb.n_checked >= 150) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(30, 60);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			gap = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(5, 25);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	function automatic int sender_gap();
		int k;
		k = $urandom_range(0, 99);
		if (burst || k < 60) return 0;
		if (k < 90) return $urandom_range(1, 3);
		return $urandom_range(6, 20);
	endfunction

	// offer one byte and hold it until taken; valid stays high for the next one
	task automatic send_byte(input logic [7:0] b);
		int g;
		g = sender_gap();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		n_sent++;
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	function automatic logic [7:0] any_but_start();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == CH_START);
		return c;
	endfunction

	// field content: mostly printable, sometimes any byte, never a framing char
	function automatic logic [7:0] body_char();
		logic [7:0] c;
		do begin
			if ($urandom_range(0, 3) != 0) c = 8'($urandom_range(8'h20, 8'h7E));
			else c = 8'($urandom_range(0, 255));
		end while (c == CH_START || c == CH_STAR || c == CH_COMMA);
		return c;
	endfunction

	// full sentence with random fields and checksum; a broken one is cut short
	task automatic send_sentence(input bit broken);
		logic [7:0] q[$];
		logic [7:0] sum;
		logic [7:0] c;
		logic [7:0] hi;
		logic [7:0] lo;
		int nf;
		int len;
		int lim;
		int k;
		int cut;
		sum = 8'h00;
		q.push_back(CH_START);
		k = $urandom_range(0, 9);
		nf = (k < 6) ? $urandom_range(1, 8) : (k < 8) ? $urandom_range(9, 19)
			: $urandom_range(20, 23);
		for (int f = 0; f < nf; f++) begin
			if (f > 0) begin
				q.push_back(CH_COMMA);
				sum ^= CH_COMMA;
			end
			lim = int'(sentence_scoreboard::char_limit((f < 19) ? f[4:0] : FIELD_SAT));
			k = $urandom_range(0, 19);
			if (lim == 0) len = $urandom_range(0, 4);
			else if (k < 12) len = $urandom_range(0, lim);
			else if (k < 17) len = lim + $urandom_range(0, 3);
			else len = $urandom_range(0, 2);
			for (int j = 0; j < len; j++) begin
				c = body_char();
				q.push_back(c);
				sum ^= c;
			end
		end
		q.push_back(CH_STAR);
		hi = sentence_scoreboard::hex_char(sum[7:4]);
		lo = sentence_scoreboard::hex_char(sum[3:0]);
		k = $urandom_range(0, 19);
		if (k < 4) begin
			// lower-case hex letters must still pass
			if (hi >= 8'h41) hi = hi | 8'h20;
			if (lo >= 8'h41) lo = lo | 8'h20;
		end else if (k < 7) begin
			if ($urandom_range(0, 1) == 0) hi = any_but_start();
			else lo = any_but_start();
		end
		q.push_back(hi);
		q.push_back(lo);
		q.push_back(($urandom_range(0, 2) == 0) ? 8'h0D : any_but_start());
		if (broken) begin
			cut = $urandom_range(1, q.size() - 1);
			while (q.size() > cut) void'(q.pop_back());
		end
		burst = ($urandom_range(0, 3) == 0);
		foreach (q[i]) send_byte(q[i]);
	endtask

	// stray bytes, now and then a lone start marker
	task automatic send_noise();
		int n;
		n = $urandom_range(1, 6);
		burst = 1'b0;
		for (int i = 0; i < n; i++)
			send_byte(($urandom_range(0, 7) == 0) ? CH_START : 8'($urandom_range(0, 255)));
	endtask

	initial begin : stimulus
		int k;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle bytes, good lower-case sum, restarts, star as a checksum
		// char, dollar restarting inside the checksum, bad sum, extreme byte values
		send_byte(8'h00);
		send_byte(8'hFF);
		send_str("$Z*5a\r");
		send_str("$x$");
		send_str("Q**$");
		send_str(",,*01\n");
		send_str("k$");
		send_byte(8'hFF);
		send_str("*FF");
		send_byte(8'h00);

		// random: mostly well-formed sentences
		while (n_sent < ITEM_TARGET) begin
			k = $urandom_range(0, 9);
			if (k < 8) send_sentence(1'b0);
			else if (k < 9) send_sentence(1'b1);
			else send_noise();
		end
		s_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d bytes: %0d sentence starts, %0d captured characters, deepest field %0d.",
			n_sent, sb.n_starts, sb.n_stored, sb.deepest_field);
		$display("Checksum verdicts: %0d good, %0d bad; %0d mismatches.",
			sb.n_good, sb.n_bad, sb.n_errors);
		if (sb.n_errors == 0) begin
			$display("[sentence_parser_xor_checksum] OK");
		end else begin
			$display("[sentence_parser_xor_checksum] ERROR");
		end
		$finish;
	end

endmodule

// File: sim.f
design/spxc_pkg.sv
design/spxc_parser.sv
design/sentence_parser_xor_checksum.sv
sim/tb_sentence_parser_xor_checksum.sv
